### sv/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned OPC_W   = 4;
    localparam int unsigned CODE_W  = 16;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned PHASE_W = 3;

    // Parser phases
    localparam logic [PHASE_W-1:0] PH_HDR0    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR1    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXTLEN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_MASK    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
    localparam logic [PHASE_W-1:0] PH_HALT    = 3'd5;

    // Result kinds
    localparam logic [KIND_W-1:0] K_DATA   = 3'd0;
    localparam logic [KIND_W-1:0] K_EMPTY  = 3'd1;
    localparam logic [KIND_W-1:0] K_CLOSE  = 3'd2;
    localparam logic [KIND_W-1:0] K_BADOP  = 3'd3;
    localparam logic [KIND_W-1:0] K_BADLEN = 3'd4;

    // Opcodes
    localparam logic [6:0] OP_CONT   = 7'd0;
    localparam logic [6:0] OP_TEXT   = 7'd1;
    localparam logic [6:0] OP_BIN    = 7'd2;
    localparam logic [6:0] OP_CLS    = 7'd8;
    localparam logic [6:0] OP_PING   = 7'd9;
    localparam logic [6:0] OP_PONG   = 7'd10;

    localparam logic [OPC_W-1:0] OPC_CLOSE = 4'd8;
    localparam logic [OPC_W-1:0] OPC_BINARY = 4'd2;

    // Seven-bit length escapes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [OPC_W-1:0]  frame_type;
        logic              frame_end;
        logic [CODE_W-1:0] close_code;
    } t_result;

endpackage

### sv/wsd_parser.sv
// Per-byte header, mask and payload parser with its frame state registers.
module wsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output wsd_pkg::t_result o_res
);
    import wsd_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [OPC_W-1:0]   r_opcode, n_opcode;
    logic               r_masked, n_masked;
    logic [LEN_W-1:0]   r_bytes_left, n_bytes_left;
    logic [1:0]         r_field_count, n_field_count;
    logic [31:0]        r_mask_key, n_mask_key;
    logic [1:0]         r_mask_index, n_mask_index;
    logic [CODE_W-1:0]  r_code_accum, n_code_accum;
    logic [1:0]         r_code_seen, n_code_seen;

    logic [6:0]        op7;
    logic [6:0]        len7;
    logic              op_ok;
    logic              cur_is_data;
    logic              do_length;
    logic              do_begin;
    logic [7:0]        key_byte;
    logic [7:0]        data_byte;
    logic              last;
    logic              res_valid;
    logic [KIND_W-1:0] res_kind;
    logic [7:0]        res_payload;
    logic              res_end;
    logic [CODE_W-1:0] res_code;

    always_comb begin
        op7   = i_byte[6:0];
        len7  = i_byte[6:0];
        op_ok = (op7 == OP_CONT) || (op7 == OP_TEXT) || (op7 == OP_BIN) ||
                (op7 == OP_CLS) || (op7 == OP_PING) || (op7 == OP_PONG);
        cur_is_data = (r_opcode <= OPC_BINARY);

        unique case (r_mask_index)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
        data_byte = r_masked ? (i_byte ^ key_byte) : i_byte;
        last      = (r_bytes_left == 16'd1);

        n_phase       = r_phase;
        n_opcode      = r_opcode;
        n_masked      = r_masked;
        n_bytes_left  = r_bytes_left;
        n_field_count = r_field_count;
        n_mask_key    = r_mask_key;
        n_mask_index  = r_mask_index;
        n_code_accum  = r_code_accum;
        n_code_seen   = r_code_seen;
        do_length     = 1'b0;
        do_begin      = 1'b0;
        res_valid     = 1'b0;
        res_kind      = K_DATA;
        res_payload   = 8'd0;
        res_end       = 1'b0;
        res_code      = '0;

        unique case (r_phase)
            PH_HDR0: begin
                n_opcode = i_byte[3:0];
                if (!op_ok) begin
                    n_phase   = PH_HALT;
                    res_valid = 1'b1;
                    res_kind  = K_BADOP;
                end else begin
                    n_phase = PH_HDR1;
                end
            end
            PH_HDR1: begin
                n_masked = i_byte[7];
                if (len7 == LEN_EXT64) begin
                    n_phase   = PH_HALT;
                    res_valid = 1'b1;
                    res_kind  = K_BADLEN;
                end else if (len7 == LEN_EXT16) begin
                    n_phase       = PH_EXTLEN;
                    n_field_count = 2'd0;
                    n_bytes_left  = '0;
                end else begin
                    n_bytes_left = {9'd0, len7};
                    do_length    = 1'b1;
                end
            end
            PH_EXTLEN: begin
                n_bytes_left = {r_bytes_left[7:0], i_byte};
                if (r_field_count == 2'd0) begin
                    n_field_count = 2'd1;
                end else begin
                    n_field_count = 2'd0;
                    do_length     = 1'b1;
                end
            end
            PH_MASK: begin
                n_mask_key = {r_mask_key[23:0], i_byte};
                if (r_field_count != 2'd3) begin
                    n_field_count = r_field_count + 2'd1;
                end else begin
                    n_field_count = 2'd0;
                    do_begin      = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_mask_index = r_mask_index + 2'd1;
                n_bytes_left = r_bytes_left - 16'd1;
                if (cur_is_data) begin
                    if (last) begin
                        n_phase = PH_HDR0;
                    end
                    res_valid   = 1'b1;
                    res_kind    = K_DATA;
                    res_payload = data_byte;
                    res_end     = last;
                end else if (r_opcode == OPC_CLOSE) begin
                    // keep only the first two payload bytes as the status code
                    if (r_code_seen != 2'd2) begin
                        n_code_accum = {r_code_accum[7:0], data_byte};
                        n_code_seen  = r_code_seen + 2'd1;
                    end
                    if (last) begin
                        n_phase   = PH_HALT;
                        res_valid = 1'b1;
                        res_kind  = K_CLOSE;
                        res_code  = (n_code_seen == 2'd2) ? n_code_accum : '0;
                    end
                end else if (last) begin
                    n_phase = PH_HDR0;
                end
            end
            PH_HALT: begin
                n_phase = PH_HALT;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (do_length) begin
            if (n_masked) begin
                n_phase       = PH_MASK;
                n_field_count = 2'd0;
                n_mask_key    = '0;
            end else begin
                do_begin = 1'b1;
            end
        end

        if (do_begin) begin
            n_mask_index = 2'd0;
            n_code_accum = '0;
            n_code_seen  = 2'd0;
            if (n_bytes_left != 16'd0) begin
                n_phase = PH_PAYLOAD;
            end else if (cur_is_data) begin
                n_phase   = PH_HDR0;
                res_valid = 1'b1;
                res_kind  = K_EMPTY;
                res_end   = 1'b1;
            end else if (r_opcode == OPC_CLOSE) begin
                n_phase   = PH_HALT;
                res_valid = 1'b1;
                res_kind  = K_CLOSE;
            end else begin
                n_phase = PH_HDR0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR0;
            r_opcode      <= '0;
            r_masked      <= 1'b0;
            r_bytes_left  <= '0;
            r_field_count <= '0;
            r_mask_key    <= '0;
            r_mask_index  <= '0;
            r_code_accum  <= '0;
            r_code_seen   <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_opcode      <= n_opcode;
            r_masked      <= n_masked;
            r_bytes_left  <= n_bytes_left;
            r_field_count <= n_field_count;
            r_mask_key    <= n_mask_key;
            r_mask_index  <= n_mask_index;
            r_code_accum  <= n_code_accum;
            r_code_seen   <= n_code_seen;
        end
    end

    assign o_res_valid       = i_accept && res_valid;
    assign o_res.kind        = res_kind;
    assign o_res.payload_byte = res_payload;
    assign o_res.frame_type  = n_opcode;
    assign o_res.frame_end   = res_end;
    assign o_res.close_code  = res_code;

endmodule

### sv/wsd_out_buf.sv
// Result register with a skid stage so the input side keeps moving under a stall until both are full.
module wsd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsd_pkg::t_result i_res,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_out_ready,
    output wsd_pkg::t_result o_res
);
    import wsd_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop = r_main_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

endmodule

### sv/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer: byte stream in, frame results out.
// Takes one received byte per transfer and can take a byte in every cycle while the
// output stage has room: each byte updates the header, length, mask-key and payload
// state, and any result it causes is registered in the output stage. A two-entry output
// stage (result register plus skid register) lets the input keep flowing while a result
// waits; the input stalls only when both entries are full. Results carry tuser = kind
// (0 payload byte, 1 empty data frame, 2 close, 3 bad opcode, 4 unsupported 64-bit
// length) and tlast on the last result of a data frame. Masked payloads are unmasked.
// After a close, bad opcode or 64-bit length result, all further bytes are absorbed
// with no result until reset.
module websocket_frame_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_type,
                                          // [27:12] close_code, [31:28] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast    // frame_end
);
    import wsd_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_res       (res),
        .o_ready     (o_s_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_res       (out_res)
    );

    assign o_m_axis_tdata = {4'd0, out_res.close_code, out_res.frame_type, out_res.payload_byte};
    assign o_m_axis_tuser = out_res.kind;
    assign o_m_axis_tlast = out_res.frame_end;

endmodule

### sv/wsd_checker.sv
// Port-level checks for the WebSocket frame deframer, bound to the top level.
module wsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    import wsd_pkg::*;

    // hold a result until it is taken
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // frame end only on data results, and an empty marker always ends its frame
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |->
            (o_m_axis_tuser == K_DATA) || (o_m_axis_tuser == K_EMPTY))
        else $error("tlast on a non-data result");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == K_EMPTY) |-> o_m_axis_tlast)
        else $error("empty frame marker without tlast");

    // payload byte only on data results, close code only on close results
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tuser == K_DATA) || (o_m_axis_tdata[7:0] == 8'd0)) &&
            ((o_m_axis_tuser == K_CLOSE) || (o_m_axis_tdata[27:12] == 16'd0)))
        else $error("stray payload or close code");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

### sim/websocket_frame_deframer_checker.sv
// Checker for the WebSocket frame deframer: predicts results from accepted bytes and compares.
`timescale 1ns / 1ps
module websocket_frame_deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] i_m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_type,
                                          // [27:12] close_code, [31:28] zero
    input  logic [2:0]  i_m_axis_tuser,   // [2:0] kind
    input  logic        i_m_axis_tlast,   // frame_end
    output int          o_fail_count,
    output int          o_pending
);
    import wsd_pkg::*;

    // Parser state mirrored from the block
    logic [PHASE_W-1:0] parse_phase;
    logic [OPC_W-1:0]   cur_opcode;
    logic               cur_masked;
    logic [LEN_W-1:0]   remaining;
    logic [1:0]         hdr_count;
    logic [31:0]        unmask_key;
    logic [1:0]         key_pos;
    logic [CODE_W-1:0]  status_accum;
    logic [1:0]         status_bytes;

    t_result expected_results[$];
    int      mismatches = 0;

    function automatic logic carries_data();
        return cur_opcode <= OPC_BINARY;
    endfunction

    task automatic queue_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] pb,
                                input logic fe, input logic [CODE_W-1:0] code);
        t_result r;
        r.kind         = kind;
        r.payload_byte = pb;
        r.frame_type   = cur_opcode;
        r.frame_end    = fe;
        r.close_code   = code;
        expected_results.insert(expected_results.size(), r);
    endtask

    // Length and key are known: start the payload or finish an empty frame.
    task automatic open_payload();
        key_pos      = 2'd0;
        status_accum = '0;
        status_bytes = 2'd0;
        if (remaining != '0) begin
            parse_phase = PH_PAYLOAD;
        end else if (carries_data()) begin
            parse_phase = PH_HDR0;
            queue_result(K_EMPTY, 8'd0, 1'b1, 16'd0);
        end else if (cur_opcode == OPC_CLOSE) begin
            parse_phase = PH_HALT;
            queue_result(K_CLOSE, 8'd0, 1'b0, 16'd0);
        end else begin
            parse_phase = PH_HDR0;
        end
    endtask

    task automatic length_done();
        if (cur_masked) begin
            parse_phase = PH_MASK;
            hdr_count   = 2'd0;
            unmask_key  = '0;
        end else begin
            open_payload();
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] d;
        logic       last;
        case (parse_phase)
            PH_HDR0: begin
                cur_opcode = b[3:0];
                if (b[6:0] <= OP_BIN || b[6:0] == OP_CLS || b[6:0] == OP_PING
                        || b[6:0] == OP_PONG) begin
                    parse_phase = PH_HDR1;
                end else begin
                    parse_phase = PH_HALT;
                    queue_result(K_BADOP, 8'd0, 1'b0, 16'd0);
                end
            end
            PH_HDR1: begin
                cur_masked = b[7];
                if (b[6:0] == LEN_EXT64) begin
                    parse_phase = PH_HALT;
                    queue_result(K_BADLEN, 8'd0, 1'b0, 16'd0);
                end else if (b[6:0] == LEN_EXT16) begin
                    parse_phase = PH_EXTLEN;
                    hdr_count   = 2'd0;
                    remaining   = '0;
                end else begin
                    remaining = {9'd0, b[6:0]};
                    length_done();
                end
            end
            PH_EXTLEN: begin
                remaining = {remaining[7:0], b};
                if (hdr_count == 2'd0) begin
                    hdr_count = 2'd1;
                end else begin
                    hdr_count = 2'd0;
                    length_done();
                end
            end
            PH_MASK: begin
                unmask_key = {unmask_key[23:0], b};
                if (hdr_count < 2'd3) begin
                    hdr_count = hdr_count + 2'd1;
                end else begin
                    hdr_count = 2'd0;
                    open_payload();
                end
            end
            PH_PAYLOAD: begin
                // key byte 0 is the most significant one
                d = cur_masked ? (b ^ unmask_key[8 * (3 - key_pos) +: 8]) : b;
                key_pos   = key_pos + 2'd1;
                remaining = remaining - 1'b1;
                last      = (remaining == '0);
                if (carries_data()) begin
                    if (last)
                        parse_phase = PH_HDR0;
                    queue_result(K_DATA, d, last, 16'd0);
                end else if (cur_opcode == OPC_CLOSE) begin
                    if (status_bytes < 2'd2) begin
                        status_accum = {status_accum[7:0], d};
                        status_bytes = status_bytes + 2'd1;
                    end
                    if (last) begin
                        parse_phase = PH_HALT;
                        queue_result(K_CLOSE, 8'd0, 1'b0,
                                     (status_bytes == 2'd2) ? status_accum : 16'd0);
                    end
                end else if (last) begin
                    parse_phase = PH_HDR0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            parse_phase  = PH_HDR0;
            cur_opcode   = '0;
            cur_masked   = 1'b0;
            remaining    = '0;
            hdr_count    = 2'd0;
            unmask_key   = '0;
            key_pos      = 2'd0;
            status_accum = '0;
            status_bytes = 2'd0;
            expected_results.delete();
        end else begin
            // results never leave in the cycle their byte arrives, so compare first
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                             $time, i_m_axis_tuser, i_m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, i_m_axis_tuser);
                    check_field("payload_byte", want.payload_byte, i_m_axis_tdata[7:0]);
                    check_field("frame_type", want.frame_type, i_m_axis_tdata[11:8]);
                    check_field("close_code", want.close_code, i_m_axis_tdata[27:12]);
                    check_field("tdata pad", 32'd0, i_m_axis_tdata[31:28]);
                    check_field("frame_end", want.frame_end, i_m_axis_tlast);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                deframe_byte(i_s_axis_tdata);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

### sim/websocket_frame_deframer_unit_tb.sv
// Testbench top for the WebSocket frame deframer: frame stream stimulus and verdict.
`timescale 1ns / 1ps
module websocket_frame_deframer_unit_tb;
    import wsd_pkg::*;

    localparam int unsigned RANDOM_BYTES    = 1150;
    localparam int unsigned HOLD_OFF_AT     = 400;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES    = 50;
    localparam int unsigned CYCLE_LIMIT     = 300000;

    typedef enum {
        END_CLOSE_CODE,
        END_CLOSE_SHORT,
        END_CLOSE_EMPTY,
        END_BAD_OPCODE,
        END_RSV_SET,
        END_HUGE_LEN
    } t_ending;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = 8'd0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_data;
    logic [2:0]  m_user;
    logic        m_last;
    int          fail_count;
    int          pending;
    int unsigned sent_count = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  rx_stream[$];

    websocket_frame_deframer_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    websocket_frame_deframer_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .i_m_axis_tlast  (m_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, a few long ones; none at all in a quiet stretch.
    function automatic int unsigned pick_idle(input bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Append one byte to the end of the stream.
    task automatic add_byte(input logic [7:0] b);
        rx_stream.insert(rx_stream.size(), b);
    endtask

    // Append one frame: header, optional 16-bit length, optional key, random payload.
    task automatic add_frame(input logic [6:0] op7, input logic masked,
                             input int unsigned len, input logic ext);
        logic [31:0] key;
        key = $urandom;
        add_byte({1'($urandom_range(0, 1)), op7});
        if (len >= 126 || ext) begin
            add_byte({masked, LEN_EXT16});
            add_byte(len[15:8]);
            add_byte(len[7:0]);
        end else begin
            add_byte({masked, len[6:0]});
        end
        if (masked) begin
            add_byte(key[31:24]);
            add_byte(key[23:16]);
            add_byte(key[15:8]);
            add_byte(key[7:0]);
        end
        for (int unsigned i = 0; i < len; i++)
            add_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        int unsigned pick;
        int unsigned len;
        int unsigned idle;
        logic [6:0]  op7;
        logic [3:0]  low_op;
        logic        ext;
        bit          send_quiet;
        t_ending     ending;

        // directed: short and masked data, empty frames, control frames, 16-bit lengths
        add_frame(OP_TEXT, 1'b0, 1, 1'b0);
        add_frame(OP_BIN, 1'b1, 2, 1'b0);
        add_frame(OP_CONT, 1'b1, 0, 1'b0);
        add_frame(OP_PING, 1'b0, 0, 1'b0);
        add_frame(OP_PONG, 1'b0, 1, 1'b0);
        add_frame(OP_TEXT, 1'b0, 0, 1'b1);
        add_frame(OP_BIN, 1'b0, 2, 1'b1);

        while (rx_stream.size() < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                op7 = OP_CONT;
            else if (pick < 50)
                op7 = OP_TEXT;
            else if (pick < 75)
                op7 = OP_BIN;
            else if (pick < 88)
                op7 = OP_PING;
            else
                op7 = OP_PONG;
            pick = $urandom_range(0, 99);
            ext  = 1'b0;
            if (pick < 10) begin
                len = 0;
            end else if (pick < 75) begin
                len = $urandom_range(1, 12);
            end else if (pick < 93) begin
                len = $urandom_range(13, 125);
            end else begin
                len = $urandom_range(0, 300);
                ext = 1'b1;
            end
            add_frame(op7, 1'($urandom_range(0, 1)), len, ext);
        end

        // the block halts on the final frame, so only one ending fits in a run
        ending = t_ending'($urandom_range(0, 5));
        case (ending)
            END_CLOSE_CODE:  add_frame(OP_CLS, 1'($urandom_range(0, 1)),
                                       $urandom_range(2, 6), 1'b0);
            END_CLOSE_SHORT: add_frame(OP_CLS, 1'($urandom_range(0, 1)), 1, 1'b0);
            END_CLOSE_EMPTY: add_frame(OP_CLS, 1'($urandom_range(0, 1)), 0,
                                       1'($urandom_range(0, 1)));
            END_BAD_OPCODE: begin
                // map 3..12 onto the reserved opcodes 3..7 and 11..15
                low_op = 4'($urandom_range(3, 12));
                if (low_op > 4'd7)
                    low_op = low_op + 4'd3;
                add_byte({1'($urandom_range(0, 1)), 3'b000, low_op});
            end
            END_RSV_SET: add_byte({1'($urandom_range(0, 1)),
                                   3'($urandom_range(1, 7)),
                                   4'($urandom_range(0, 15))});
            default: begin
                add_byte({1'b1, OP_BIN});
                add_byte({1'($urandom_range(0, 1)), LEN_EXT64});
            end
        endcase
        // bytes after the halt must be absorbed silently
        repeat (8)
            add_byte(8'($urandom_range(0, 255)));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_quiet = 1'b0;
        foreach (rx_stream[i]) begin
            if ($urandom_range(0, 63) == 0)
                send_quiet = ~send_quiet;
            idle = pick_idle(send_quiet);
            if (idle != 0) begin
                s_valid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            s_valid <= 1'b1;
            s_data  <= rx_stream[i];
            @(posedge clk);
            while (!s_ready)
                @(posedge clk);
            sent_count <= sent_count + 1;
        end
        s_valid <= 1'b0;

        // let the checker see the last transfer before trusting its count
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off while bytes keep coming.
    initial begin : receiver
        logic        level;
        int unsigned span;
        bit          held_off;
        bit          recv_quiet;
        held_off   = 1'b0;
        recv_quiet = 1'b0;
        forever begin
            if (!held_off && sent_count >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                level    = 1'b0;
                span     = HOLD_OFF_CYCLES;
            end else begin
                if ($urandom_range(0, 63) == 0)
                    recv_quiet = ~recv_quiet;
                span = pick_idle(recv_quiet);
                if (span == 0) begin
                    level = 1'b1;
                    span  = $urandom_range(1, 6);
                end else begin
                    level = 1'b0;
                end
            end
            m_ready <= level;
            repeat (span) @(posedge clk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

endmodule

### files.f
sv/wsd_pkg.sv
sv/wsd_parser.sv
sv/wsd_out_buf.sv
sv/websocket_frame_deframer_unit.sv
sv/wsd_checker.sv
sim/websocket_frame_deframer_checker.sv
sim/websocket_frame_deframer_unit_tb.sv
